// ===== hdl/f2h_pkg.sv =====
// Package with action codes and conversion functions for the fp32/fp16 converter.
`default_nettype none
package f2h_pkg;

    typedef enum logic [1:0] {
        ACT_NARROW = 2'd0,
        ACT_WIDEN  = 2'd1,
        ACT_ROUND  = 2'd2,
        ACT_NONE   = 2'd3
    } t_action;

    localparam logic [15:0] QNAN16 = 16'h7e00;
    localparam logic [15:0] INF16  = 16'h7c00;
    localparam logic [31:0] INF32  = 32'h7f800000;

    function automatic logic [15:0] narrow(input logic [31:0] bits);
        logic        sgn;
        logic [7:0]  ex;
        logic [22:0] man;
        logic [23:0] mfull;
        logic [4:0]  sh;
        logic [23:0] q;
        logic        half;
        logic [23:0] restmask;
        logic        rest;
        logic [10:0] hman;
        logic [5:0]  hexp;
        logic [15:0] res;
        sgn   = bits[31];
        ex    = bits[30:23];
        man   = bits[22:0];
        mfull = {1'b1, man};
        sh    = 5'(8'd126 - ex);
        q     = mfull >> sh;
        half  = mfull[sh - 5'd1];
        restmask = (24'd1 << (sh - 5'd1)) - 24'd1;
        rest  = |(mfull & restmask);
        hexp  = 6'(ex - 8'd112);
        hman  = {1'b0, man[22:13]};
        if (ex == 8'hff) begin
            res = {sgn, (man != '0) ? QNAN16[14:0] : INF16[14:0]};
        end else if (ex > 8'd142) begin
            res = {sgn, INF16[14:0]};
        end else if (ex < 8'd102) begin
            res = {sgn, 15'd0};
        end else if (ex < 8'd113) begin
            // Subnormal result; a carry out lands on the smallest normal naturally.
            if (half && (rest || q[0]))
                q = q + 24'd1;
            res = {sgn, q[14:0]};
        end else begin
            if (man[12] && ((|man[11:0]) || hman[0])) begin
                hman = hman + 11'd1;
                if (hman[10]) begin
                    hman = '0;
                    hexp = hexp + 6'd1;
                end
            end
            if (hexp >= 6'd31)
                res = {sgn, INF16[14:0]};
            else
                res = {sgn, hexp[4:0], hman[9:0]};
        end
        return res;
    endfunction

    function automatic logic [31:0] widen(input logic [15:0] h);
        logic        sgn;
        logic [4:0]  ex;
        logic [9:0]  man;
        logic [3:0]  lz;
        logic [9:0]  nm;
        logic [31:0] res;
        sgn = h[15];
        ex  = h[14:10];
        man = h[9:0];
        lz  = 4'd0;
        for (int i = 0; i < 10; i++) begin
            if (man[i])
                lz = 4'(9 - i);
        end
        // Shift the leading one out of the field to normalize.
        nm  = 10'(man << (lz + 4'd1));
        if (ex == 5'd0) begin
            if (man == '0)
                res = {sgn, 31'd0};
            else
                res = {sgn, 8'(8'd112 - 8'(lz)), nm, 13'd0};
        end else if (ex == 5'd31) begin
            res = {sgn, INF32[30:23], man, 13'd0};
        end else begin
            res = {sgn, 8'(8'(ex) + 8'd112), man, 13'd0};
        end
        return res;
    endfunction

endpackage
`default_nettype wire

// ===== hdl/f2h_datapath.sv =====
// Combinational conversion between the input and result registers.
`default_nettype none
module f2h_datapath
    import f2h_pkg::*;
(
    input  wire logic [1:0]  i_action,
    input  wire logic [31:0] i_value,
    output logic [31:0]      o_value
);
    logic [15:0] w_half;

    assign w_half = narrow(i_value);

    always_comb begin
        unique case (t_action'(i_action))
            ACT_NARROW: o_value = {16'd0, w_half};
            ACT_WIDEN:  o_value = widen(i_value[15:0]);
            ACT_ROUND:  o_value = widen(w_half);
            default:    o_value = '0;
        endcase
    end
endmodule
`default_nettype wire

// ===== hdl/fp32_fp16_converter_core.sv =====
// Top level: fp32/fp16 format converter with input and result registers.
// Pipeline: a beat passes the input register, then the result register, to the output.
// Throughput: one beat per cycle unless i_ready stalls; conversion logic lies between them.
// Reset: synchronous active-low i_rst_n clears both valid flags; payloads are not reset.
`default_nettype none
module fp32_fp16_converter_core
    import f2h_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_ready,
    input  wire logic [1:0]  i_action,
    input  wire logic [31:0] i_value_in,
    output logic             o_valid,
    input  wire logic        i_ready,
    output logic [31:0]      o_value_out
);
    logic        r_in_valid;
    logic [1:0]  r_action;
    logic [31:0] r_value;
    logic        r_out_valid;
    logic [31:0] r_result;
    logic [31:0] w_conv;
    logic        w_adv;

    // The result register can take a beat when empty or draining this cycle.
    assign w_adv   = !r_out_valid || i_ready;
    assign o_ready = !r_in_valid || w_adv;

    f2h_datapath u_dp (
        .i_action (r_action),
        .i_value  (r_value),
        .o_value  (w_conv)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_ready)
                r_in_valid <= i_valid;
            if (w_adv)
                r_out_valid <= r_in_valid;
        end
        if (o_ready && i_valid) begin
            r_action <= i_action;
            r_value  <= i_value_in;
        end
        if (w_adv && r_in_valid)
            r_result <= w_conv;
    end

    assign o_valid     = r_out_valid;
    assign o_value_out = r_result;

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_value_out))
        else $error("result changed while stalled");
    a_flow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_valid && w_adv |=> o_valid)
        else $error("converted beat lost");
    a_narrow_hi: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_valid && w_adv && r_action == ACT_NARROW |=> o_value_out[31:16] == 16'd0)
        else $error("narrow result upper half not zero");
endmodule
`default_nettype wire

// ===== tb/fp32_fp16_converter_core_tb.sv =====
// Self-checking testbench for the fp32/fp16 format converter core.
`timescale 1ns / 1ps
module fp32_fp16_converter_core_tb;
    import f2h_pkg::*;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic        o_ready;
    logic [1:0]  i_action = ACT_NARROW;
    logic [31:0] i_value_in = '0;
    logic        o_valid;
    logic        i_ready = 1'b0;
    logic [31:0] o_value_out;

    typedef struct packed {
        logic [1:0]  action;
        logic [31:0] value;
    } t_conv_item;

    t_conv_item  pending_q[$];
    logic [31:0] expected_q[$];
    int          send_idle_pct = 0;
    int          recv_stall_pct = 0;
    bit          failed = 1'b0;
    bit          in_taken = 1'b0;
    longint      cycle_cnt = 0;

    fp32_fp16_converter_core DUT (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .o_ready(o_ready),
        .i_action(i_action), .i_value_in(i_value_in), .o_valid(o_valid),
        .i_ready(i_ready), .o_value_out(o_value_out)
    );

    always #2 i_clk = ~i_clk;

    // Binary32 to binary16, round to nearest even.
    function automatic logic [15:0] to_half(input logic [31:0] f);
        logic [15:0] sg;
        logic [7:0]  ex;
        logic [23:0] mt;
        logic [23:0] q;
        logic [4:0]  sh;
        logic        rb;
        logic        sticky;
        logic [5:0]  he;
        logic [10:0] hm;
        sg = {f[31], 15'd0};
        ex = f[30:23];
        mt = {1'b0, f[22:0]};
        if (ex == 8'hff) return sg | (mt != 0 ? 16'h7e00 : 16'h7c00);
        if (ex > 8'd142) return sg | 16'h7c00;
        if (ex < 8'd102) return sg;
        if (ex < 8'd113) begin
            mt[23] = 1'b1;
            sh = 5'(8'd126 - ex);
            q = mt >> sh;
            rb = mt[sh - 5'd1];
            sticky = (mt & ((24'd1 << (sh - 5'd1)) - 24'd1)) != 0;
            if (rb && (sticky || q[0])) q = q + 24'd1;
            return sg | q[15:0];
        end
        he = 6'(ex - 8'd112);
        hm = {1'b0, mt[22:13]};
        if (mt[12] && (mt[11:0] != 0 || hm[0])) begin
            hm = hm + 11'd1;
            if (hm == 11'h400) begin
                hm = '0;
                he = he + 6'd1;
                if (he >= 6'd31) return sg | 16'h7c00;
            end
        end
        return sg | {1'b0, he[4:0], hm[9:0]};
    endfunction

    // Binary16 to binary32, exact.
    function automatic logic [31:0] to_single(input logic [15:0] h);
        logic [31:0] sg;
        logic [4:0]  ex;
        logic [10:0] mt;
        logic [7:0]  e;
        sg = {h[15], 31'd0};
        ex = h[14:10];
        mt = {1'b0, h[9:0]};
        if (ex == 0) begin
            if (mt == 0) return sg;
            e = 8'd113;
            while (!mt[10]) begin
                mt = mt << 1;
                e = e - 8'd1;
            end
            return sg | {1'b0, e, mt[9:0], 13'd0};
        end
        if (ex == 5'd31) return sg | 32'h7f800000 | {9'd0, mt[9:0], 13'd0};
        return sg | {1'b0, 8'(ex) + 8'd112, mt[9:0], 13'd0};
    endfunction

    function automatic logic [31:0] convert(input logic [1:0] act, input logic [31:0] v);
        case (act)
            ACT_NARROW: return {16'd0, to_half(v)};
            ACT_WIDEN:  return to_single(v[15:0]);
            ACT_ROUND:  return to_single(to_half(v));
            default:    return '0;
        endcase
    endfunction

    // Random binary32, exponent biased to interesting ranges or low mantissa bits near a tie.
    function automatic logic [31:0] rand_single();
        logic [31:0] v;
        v = $urandom;
        case ($urandom_range(0, 5))
            0, 1: v[30:23] = 8'($urandom_range(100, 145));
            2:    v[30:23] = $urandom_range(0, 1) ? 8'hff : 8'h00;
            3:    v[12:0] = $urandom_range(0, 1) ? 13'h1000 : 13'h0fff;
            default: ;
        endcase
        return v;
    endfunction

    // The previous beat counts as sent only if it was accepted at the last rising edge.
    always @(negedge i_clk) begin
        if (i_rst_n) begin
            if (!i_valid || in_taken) begin
                if (pending_q.size() != 0 && $urandom_range(1, 100) > send_idle_pct) begin
                    i_valid    <= 1'b1;
                    i_action   <= pending_q[0].action;
                    i_value_in <= pending_q[0].value;
                    void'(pending_q.pop_front());
                end else begin
                    i_valid <= 1'b0;
                end
            end
            i_ready <= ($urandom_range(1, 100) > recv_stall_pct);
        end
    end

    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        in_taken  <= i_valid && o_ready;
        if (i_rst_n) begin
            if (i_valid && o_ready) expected_q.push_back(convert(i_action, i_value_in));
            if (o_valid && i_ready) begin
                if (expected_q.size() == 0) begin
                    $error("value_out: unexpected beat, actual %h", o_value_out);
                    failed = 1'b1;
                end else begin
                    if (o_value_out !== expected_q[0]) begin
                        $error("value_out: expected %h actual %h", expected_q[0], o_value_out);
                        failed = 1'b1;
                    end
                    void'(expected_q.pop_front());
                end
            end
        end
        if (cycle_cnt > 200000) begin
            $display("FAIL");
            $finish;
        end
    end

    task automatic add_item(input logic [1:0] act, input logic [31:0] v);
        t_conv_item it;
        it.action = act;
        it.value = v;
        pending_q.push_back(it);
    endtask

    task automatic drain();
        while (pending_q.size() != 0 || i_valid || expected_q.size() != 0)
            @(posedge i_clk);
    endtask

    initial begin
        logic [31:0] v;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        // Directed: specials, overflow boundary, subnormals, ties, unused action.
        add_item(ACT_NARROW, 32'h7fc01234);
        add_item(ACT_NARROW, 32'hff800000);
        add_item(ACT_NARROW, 32'h477fefff);
        add_item(ACT_NARROW, 32'h477ff000);
        add_item(ACT_NARROW, 32'h47800000);
        add_item(ACT_NARROW, 32'h33000000);
        add_item(ACT_NARROW, 32'h33000001);
        add_item(ACT_NARROW, 32'h387fe000);
        add_item(ACT_NARROW, 32'h387ff000);
        add_item(ACT_NARROW, 32'h80000001);
        add_item(ACT_NARROW, 32'h3f801000);
        add_item(ACT_NARROW, 32'h3f803000);
        add_item(ACT_NARROW, 32'h32ffffff);
        add_item(ACT_WIDEN,  32'hffff7d01);
        add_item(ACT_WIDEN,  32'h0000fc00);
        add_item(ACT_WIDEN,  32'h00000001);
        add_item(ACT_WIDEN,  32'h000083ff);
        add_item(ACT_WIDEN,  32'h00007bff);
        add_item(ACT_WIDEN,  32'h00008000);
        add_item(ACT_ROUND,  32'h3f800fff);
        add_item(ACT_ROUND,  32'hc77ff000);
        add_item(ACT_ROUND,  32'h33800000);
        add_item(ACT_NONE,   32'hffffffff);
        add_item(ACT_NONE,   32'h00000000);
        drain();
        for (int ph = 0; ph < 4; ph++) begin
            send_idle_pct  = (ph == 1 || ph == 3) ? ((ph == 1) ? 51 : 7) : 0;
            recv_stall_pct = (ph == 2 || ph == 3) ? ((ph == 2) ? 51 : 7) : 0;
            for (int n = 0; n < 410; n++) begin
                v = $urandom_range(0, 3) == 0 ? $urandom : rand_single();
                add_item(2'($urandom_range(0, 9) == 0 ? 3 : $urandom_range(0, 2)), v);
            end
            drain();
        end
        repeat (20) @(posedge i_clk);
        if (!failed) $display("PASS");
        else $display("FAIL");
        $finish;
    end
endmodule
